### sv/assert_macros.svh
// Assertion macros used by the hash block controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define XS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define XS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/xsha1_pkg.sv
// Shared types, constants and round functions of the hash block
package xsha1_pkg;

  localparam int NUM_CONTEXTS = 3;
  localparam int BLOCK_WORDS  = 16;
  localparam int DIGEST_WORDS = 5;
  localparam int NUM_ROUNDS   = 80;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] IDX_LAST = 3'(DIGEST_WORDS - 1);

  typedef logic [31:0] word_t;

  // Command bundle from the controller to the datapath
  typedef struct packed {
    logic       shift_in;   // push a message word into the block buffer
    logic       blk_start;  // latch context, load working words
    logic       round;      // run one round, advance the schedule
    logic [1:0] phase;      // round group: 0..3
    logic       add;        // fold working words into chaining words
    logic       emit;       // register one digest word
    logic [2:0] idx;        // digest word index for emit
    logic       init;       // load IV into the addressed context
    logic       clear;      // zero all contexts
  } xs_cmd_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0:    r = 32'h67452301;
      3'd1:    r = 32'hEFCDAB89;
      3'd2:    r = 32'h98BADCFE;
      3'd3:    r = 32'h10325476;
      3'd4:    r = 32'hC3D2E1F0;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [1:0] ph);
    word_t r;
    case (ph)
      2'd0:    r = 32'h5A827999;
      2'd1:    r = 32'h6ED9EBA1;
      2'd2:    r = 32'h8F1BBCDC;
      default: r = 32'hCA62C1D6;
    endcase
    return r;
  endfunction

  // Rotate left by 5; a set sign bit fills the upper bits with ones
  function automatic word_t frot5(input word_t x);
    return x[31] ? {27'h7FFFFFF, x[31:27]} : {x[26:0], x[31:27]};
  endfunction

  // Rotate left by 30; a set sign bit fills the upper bits with ones
  function automatic word_t frot30(input word_t x);
    return x[31] ? {2'b11, x[31:2]} : {x[1:0], x[31:2]};
  endfunction

endpackage

### sv/xsha1_dp.sv
// Datapath: block buffer and schedule, round unit, chaining words, digest register
module xsha1_dp
  import xsha1_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  xs_cmd_t       cmd,
  input  logic [1:0]    ctx_sel,
  input  logic [31:0]   msg_word,
  output logic [31:0]   digest_word,
  output logic [1:0]    digest_ctx
);

  word_t      blk [BLOCK_WORDS];
  word_t      chain [NUM_CONTEXTS][DIGEST_WORDS];
  word_t      wa, wb, wc, wd, we;
  logic [1:0] ctx_q;
  word_t      f_val;
  word_t      t_val;
  word_t      w_next;

  // Round function and schedule feedback
  always_comb begin
    case (cmd.phase)
      2'd0:    f_val = (wb & wc) | (~wb & wd);
      2'd2:    f_val = (wb & wc) | (wb & wd) | (wc & wd);
      default: f_val = wb ^ wc ^ wd;
    endcase
    t_val  = frot5(wa) + f_val + we + blk[0] + round_k(cmd.phase);
    w_next = blk[0] ^ blk[2] ^ blk[8] ^ blk[13];
  end

  // Block buffer as a shift line: loads push the word, rounds push the schedule
  always_ff @(posedge clk) begin
    if (cmd.shift_in || cmd.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        blk[i] <= blk[i + 1];
      end
      blk[BLOCK_WORDS - 1] <= cmd.round ? w_next : msg_word;
    end
  end

  // Working words and latched context
  always_ff @(posedge clk) begin
    if (cmd.blk_start) begin
      ctx_q <= ctx_sel;
      wa    <= chain[ctx_sel][0];
      wb    <= chain[ctx_sel][1];
      wc    <= chain[ctx_sel][2];
      wd    <= chain[ctx_sel][3];
      we    <= chain[ctx_sel][4];
    end else if (cmd.round) begin
      wa <= t_val;
      wb <= wa;
      wc <= frot30(wb);
      wd <= wc;
      we <= wd;
    end
  end

  // Chaining words: clear, init, block update
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain[c][i] <= '0;
        end
      end
    end else if (cmd.init) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[ctx_sel][i] <= iv_word(3'(i));
      end
    end else if (cmd.add) begin
      chain[ctx_q][0] <= chain[ctx_q][0] + wa;
      chain[ctx_q][1] <= chain[ctx_q][1] + wb;
      chain[ctx_q][2] <= chain[ctx_q][2] + wc;
      chain[ctx_q][3] <= chain[ctx_q][3] + wd;
      chain[ctx_q][4] <= chain[ctx_q][4] + we;
    end
  end

  // Digest output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest_word <= chain[ctx_q][cmd.idx];
      digest_ctx  <= ctx_q;
    end
  end

endmodule

### sv/xsha1_ctrl.sv
// Controller: item decode, fill count, round sequencing, digest strobe
module xsha1_ctrl
  import xsha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  logic [1:0]  ctx_sel,
  output logic        busy,
  output xs_cmd_t     cmd,
  output logic        strobe,
  output logic [2:0]  digest_index,
  output logic        last
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_OUT} state_t;

  state_t     state;
  logic [3:0] fill_count;
  logic [6:0] rnd;
  logic [2:0] out_idx;
  logic       accept;
  logic       ctx_ok;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);
  assign ctx_ok = int'(ctx_sel) < NUM_CONTEXTS;

  // Decode commands for the datapath
  always_comb begin
    cmd           = '0;
    cmd.shift_in  = accept && (op == OP_LOAD);
    cmd.blk_start = accept && (op == OP_LOAD) && (fill_count == 4'hF) && ctx_ok;
    cmd.init      = accept && (op == OP_INIT) && ctx_ok;
    cmd.clear     = accept && (op == OP_CLEAR);
    cmd.round     = (state == ST_ROUND);
    cmd.add       = (state == ST_ADD);
    cmd.emit      = (state == ST_OUT);
    cmd.idx       = out_idx;
    if (rnd < 7'd20) begin
      cmd.phase = 2'd0;
    end else if (rnd < 7'd40) begin
      cmd.phase = 2'd1;
    end else if (rnd < 7'd60) begin
      cmd.phase = 2'd2;
    end else begin
      cmd.phase = 2'd3;
    end
  end

  // State, counters and registered strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      rnd          <= '0;
      out_idx      <= '0;
      strobe       <= 1'b0;
      digest_index <= '0;
      last         <= 1'b0;
    end else begin
      strobe       <= cmd.emit;
      digest_index <= out_idx;
      last         <= cmd.emit && (out_idx == IDX_LAST);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD: begin
                fill_count <= fill_count + 4'd1;
                if (cmd.blk_start) begin
                  rnd   <= '0;
                  state <= ST_ROUND;
                end
              end
              OP_INIT:  fill_count <= '0;
              OP_CLEAR: fill_count <= '0;
              default:  ;
            endcase
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'(NUM_ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          out_idx <= '0;
          state   <= ST_OUT;
        end
        ST_OUT: begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == IDX_LAST) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `XS_ASSERT(a_burst_cont, strobe && !last |=> strobe, "digest burst broken")
  `XS_ASSERT(a_last_idx, last |-> strobe && (digest_index == IDX_LAST), "last on wrong word")
  `XS_ASSERT(a_burst_head, $rose(strobe) |-> (digest_index == 3'd0), "burst not at index 0")
  `XS_ASSERT(a_busy_out, strobe && !last |-> busy, "accepting inside a digest burst")
  `XS_ASSERT_ALWAYS(a_rst_quiet, rst |=> !strobe, "strobe right after reset")

endmodule

### sv/xsha1_block_hash.sv
// Top level: variant SHA-0 style compression over several hash contexts
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   command  | start / busy       | op, ctx_sel, msg_word
//   digest   | strobe (no stall)  | digest_word, digest_index, digest_ctx, last
//
// Init, clear and non-final loads leave busy low.
// The sixteenth load of a block, with a valid ctx_sel, keeps busy high through all
// rounds on the single round unit, one chaining add and the five digest words;
// strobe follows each emit in the next cycle. No item is accepted while busy is high.
// Synchronous reset zeroes all chaining words and the fill count.
// The receiver cannot stall: strobe marks each digest word for exactly one cycle.
module xsha1_block_hash
  import xsha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [1:0]  ctx_sel,
  input  logic [31:0] msg_word,
  output logic        strobe,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic [1:0]  digest_ctx,
  output logic        last
);

  xs_cmd_t cmd;

  xsha1_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .ctx_sel      (ctx_sel),
    .busy         (busy),
    .cmd          (cmd),
    .strobe       (strobe),
    .digest_index (digest_index),
    .last         (last)
  );

  xsha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .ctx_sel     (ctx_sel),
    .msg_word    (msg_word),
    .digest_word (digest_word),
    .digest_ctx  (digest_ctx)
  );

endmodule
